// ===== rtl/core/slbc_pkg.sv =====
package slbc_pkg;

   localparam int TIME_W   = 32;
   localparam int PERIOD_W = 20;
   localparam int LEVEL_W  = 8;
   localparam int MIN_LINE = 3;

   localparam logic [PERIOD_W-1:0] PERIOD_MAX = 20'hFFFFF;

   localparam logic [7:0] CHR_B     = 8'h42;
   localparam logic [7:0] CHR_E     = 8'h45;
   localparam logic [7:0] CHR_D     = 8'h44;
   localparam logic [7:0] CHR_COMMA = 8'h2C;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_VT    = 8'h0B;
   localparam logic [7:0] CHR_FF    = 8'h0C;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] LED_BASE  = 8'h33;
   localparam logic [7:0] LED_TOP   = 8'h3A;

   typedef enum logic [0:0] {
      ALU_DIFF = 1'b0,
      ALU_MAC  = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type            op;
      logic [TIME_W-1:0]     a;
      logic [TIME_W-1:0]     b;
      logic [PERIOD_W-1:0]   limit;
      logic [PERIOD_W-1:0]   acc;
      logic [3:0]            digit;
   } alu_req_type;

   typedef struct packed {
      logic                  ge;
      logic [PERIOD_W-1:0]   value;
   } alu_rsp_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CHECK = 7'b0000010,
      ST_SCAN  = 7'b0000100,
      ST_SKIP  = 7'b0001000,
      ST_DIGIT = 7'b0010000,
      ST_TICK  = 7'b0100000,
      ST_SPARE = 7'b1000000
   } state_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_LF) ||
             (c == CHR_VT) || (c == CHR_FF) || (c == CHR_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHR_ZERO) && (c <= CHR_NINE);
   endfunction

endpackage

// ===== rtl/core/slbc_alu.sv =====
module slbc_alu (
   input  slbc_pkg::alu_req_type req,
   output slbc_pkg::alu_rsp_type rsp
);

   logic [slbc_pkg::TIME_W-1:0] x;
   logic [slbc_pkg::TIME_W-1:0] y;
   logic                        cin;
   logic [slbc_pkg::TIME_W-1:0] sum;

   // One adder serves both the elapsed-time subtraction and the decimal
   // accumulate step, where the value is multiplied by ten as 8v + 2v.
   always_comb begin
      if (req.op == slbc_pkg::ALU_MAC) begin
         x   = {{(slbc_pkg::TIME_W - slbc_pkg::PERIOD_W - 3){1'b0}}, req.acc, 3'b000};
         y   = {{(slbc_pkg::TIME_W - slbc_pkg::PERIOD_W - 1){1'b0}}, req.acc, 1'b0}
               + {{(slbc_pkg::TIME_W - 4){1'b0}}, req.digit};
         cin = 1'b0;
      end else begin
         x   = req.a;
         y   = ~req.b;
         cin = 1'b1;
      end
      sum = x + y + {{(slbc_pkg::TIME_W - 1){1'b0}}, cin};
   end

   assign rsp.ge    = sum >= {{(slbc_pkg::TIME_W - slbc_pkg::PERIOD_W){1'b0}}, req.limit};
   assign rsp.value = (sum > {{(slbc_pkg::TIME_W - slbc_pkg::PERIOD_W){1'b0}},
                              slbc_pkg::PERIOD_MAX})
                      ? slbc_pkg::PERIOD_MAX : sum[slbc_pkg::PERIOD_W-1:0];

endmodule

// ===== rtl/core/slbc_line_buf.sv =====
module slbc_line_buf #(
   parameter int LINE_LEN = 10
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(LINE_LEN)-1:0] wr_addr,
   input  logic [7:0]                  wr_data,
   input  logic [$clog2(LINE_LEN)-1:0] rd_addr,
   output logic [7:0]                  rd_data,
   output logic [7:0]                  head_op,
   output logic [7:0]                  head_led
);

   logic [7:0] mem_ff [LINE_LEN];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data  = mem_ff[rd_addr];
   assign head_op  = mem_ff[0];
   assign head_led = mem_ff[1];

endmodule

// ===== rtl/core/serial_led_blink_command_controller_core.sv =====
// Channel | Direction | Transfer contents
// req     | in        | tdata[7:0] rx_byte; tuser[0] operation (1 = millisecond tick)
// rsp     | out       | tdata[7:0] led_levels; tdata[8] command_accepted
//
// A byte that does not end a line is finished in the idle state; its result is loaded at the transfer.
// A tick walks the LEDs through the shared subtract-compare unit.
// An ending line is executed from the buffer; no new byte is taken until it has finished.
// Synchronous reset clears the sequencer, LED state, line count and the time counter.
// req_tready is high only in the idle state while the result register is free or being taken.
module serial_led_blink_command_controller_core #(
   parameter int LINE_LEN  = 10,
   parameter int LED_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic [0:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // led_levels, command_accepted, zero fill
);

   localparam int IDX_W = $clog2(LINE_LEN);
   localparam int POS_W = $clog2(LINE_LEN + 1);
   localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   slbc_pkg::state_type state_ff, state_in;
   logic [POS_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [slbc_pkg::PERIOD_W-1:0] val_ff, val_in;
   logic [LED_W-1:0] idx_ff, idx_in;
   logic [LED_W-1:0] ptr_ff, ptr_in;
   logic [slbc_pkg::TIME_W-1:0] time_ff, time_in;
   logic [slbc_pkg::TIME_W-1:0] last_ff [LED_COUNT];
   logic [slbc_pkg::TIME_W-1:0] last_in [LED_COUNT];
   logic [slbc_pkg::PERIOD_W-1:0] period_ff [LED_COUNT];
   logic [slbc_pkg::PERIOD_W-1:0] period_in [LED_COUNT];
   logic [LED_COUNT-1:0] on_ff, on_in;
   logic [LED_COUNT-1:0] drive_ff, drive_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [slbc_pkg::LEVEL_W-1:0] rsp_levels_ff, rsp_levels_in;
   logic rsp_acc_ff, rsp_acc_in;

   logic req_fire;
   logic eol;
   logic in_range;
   logic wr_en;
   logic [7:0] rd_data;
   logic [7:0] head_op;
   logic [7:0] head_led;
   logic [7:0] led_diff;
   logic led_ok;
   logic [LED_W-1:0] apply_idx;
   logic apply_b;
   logic apply_ed;
   logic [slbc_pkg::PERIOD_W-1:0] apply_val;
   logic finish;
   logic fin_acc;
   logic clear_line;
   logic toggle;
   slbc_pkg::alu_req_type alu_req;
   slbc_pkg::alu_rsp_type alu_rsp;

   assign req_tready = (state_ff == slbc_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign eol        = (req_tdata == slbc_pkg::CHR_CR) || (req_tdata == slbc_pkg::CHR_LF);
   assign in_range   = pos_ff < count_ff;
   assign led_diff   = head_led - slbc_pkg::LED_BASE;
   assign led_ok     = (head_led >= slbc_pkg::LED_BASE) && (head_led <= slbc_pkg::LED_TOP) &&
                       (led_diff < 8'(LED_COUNT));

   slbc_line_buf #(
      .LINE_LEN(LINE_LEN)
   ) u_line_buf (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (count_ff[IDX_W-1:0]),
      .wr_data  (req_tdata),
      .rd_addr  (pos_ff[IDX_W-1:0]),
      .rd_data  (rd_data),
      .head_op  (head_op),
      .head_led (head_led)
   );

   slbc_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      ptr_in        = ptr_ff;
      time_in       = time_ff;
      last_in       = last_ff;
      period_in     = period_ff;
      on_in         = on_ff;
      drive_in      = drive_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_levels_in = rsp_levels_ff;
      rsp_acc_in    = rsp_acc_ff;
      wr_en         = 1'b0;
      apply_idx     = idx_ff;
      apply_b       = 1'b0;
      apply_ed      = 1'b0;
      apply_val     = '0;
      finish        = 1'b0;
      fin_acc       = 1'b0;
      clear_line    = 1'b0;
      toggle        = 1'b0;
      alu_req.op    = slbc_pkg::ALU_DIFF;
      alu_req.a     = time_ff;
      alu_req.b     = last_ff[ptr_ff];
      alu_req.limit = period_ff[ptr_ff];
      alu_req.acc   = val_ff;
      alu_req.digit = rd_data[3:0] - slbc_pkg::CHR_ZERO[3:0];

      unique case (state_ff)
         slbc_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser[0]) begin
                  time_in  = time_ff + 32'd1;
                  ptr_in   = '0;
                  state_in = slbc_pkg::ST_TICK;
               end else if (count_ff < POS_W'(LINE_LEN)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + POS_W'(1);
                  if (eol) begin
                     state_in = slbc_pkg::ST_CHECK;
                  end else begin
                     finish = 1'b1;
                  end
               end else begin
                  if (eol) begin
                     count_in = '0;
                  end
                  finish = 1'b1;
               end
            end
         end
         slbc_pkg::ST_CHECK: begin
            apply_idx = led_diff[LED_W-1:0];
            idx_in    = led_diff[LED_W-1:0];
            if ((count_ff < POS_W'(slbc_pkg::MIN_LINE)) || !led_ok) begin
               clear_line = 1'b1;
            end else if ((head_op == slbc_pkg::CHR_E) || (head_op == slbc_pkg::CHR_D)) begin
               apply_ed   = 1'b1;
               fin_acc    = 1'b1;
               clear_line = 1'b1;
            end else if (head_op == slbc_pkg::CHR_B) begin
               pos_in   = POS_W'(2);
               state_in = slbc_pkg::ST_SCAN;
            end else begin
               clear_line = 1'b1;
            end
         end
         slbc_pkg::ST_SCAN: begin
            if (!in_range) begin
               clear_line = 1'b1;
            end else if (rd_data == slbc_pkg::CHR_COMMA) begin
               pos_in   = pos_ff + POS_W'(1);
               val_in   = '0;
               state_in = slbc_pkg::ST_SKIP;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
         slbc_pkg::ST_SKIP: begin
            if (!in_range || (rd_data == slbc_pkg::CHR_MINUS)) begin
               apply_b    = 1'b1;
               fin_acc    = 1'b1;
               clear_line = 1'b1;
            end else if (slbc_pkg::is_space(rd_data)) begin
               pos_in = pos_ff + POS_W'(1);
            end else if (rd_data == slbc_pkg::CHR_PLUS) begin
               pos_in   = pos_ff + POS_W'(1);
               state_in = slbc_pkg::ST_DIGIT;
            end else begin
               state_in = slbc_pkg::ST_DIGIT;
            end
         end
         slbc_pkg::ST_DIGIT: begin
            alu_req.op = slbc_pkg::ALU_MAC;
            if (in_range && slbc_pkg::is_digit(rd_data)) begin
               val_in = alu_rsp.value;
               pos_in = pos_ff + POS_W'(1);
            end else begin
               apply_b    = 1'b1;
               apply_val  = val_ff;
               fin_acc    = 1'b1;
               clear_line = 1'b1;
            end
         end
         slbc_pkg::ST_TICK: begin
            toggle = on_ff[ptr_ff] && (period_ff[ptr_ff] != '0) && alu_rsp.ge;
            if (ptr_ff == LED_W'(LED_COUNT - 1)) begin
               finish   = 1'b1;
               state_in = slbc_pkg::ST_IDLE;
            end else begin
               ptr_in = ptr_ff + LED_W'(1);
            end
         end
         default: begin
            state_in = slbc_pkg::ST_IDLE;
         end
      endcase

      for (int i = 0; i < LED_COUNT; i++) begin
         if (apply_b && (apply_idx == LED_W'(i))) begin
            period_in[i] = apply_val;
            on_in[i]     = apply_val != '0;
            last_in[i]   = time_ff;
         end
         if (apply_ed && (apply_idx == LED_W'(i))) begin
            period_in[i] = '0;
            on_in[i]     = 1'b0;
            drive_in[i]  = (head_op == slbc_pkg::CHR_E);
         end
         if (toggle && (ptr_ff == LED_W'(i))) begin
            drive_in[i] = !drive_ff[i];
            last_in[i]  = time_ff;
         end
      end

      if (clear_line) begin
         count_in = '0;
         finish   = 1'b1;
         state_in = slbc_pkg::ST_IDLE;
      end

      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_levels_in = slbc_pkg::LEVEL_W'(drive_in);
         rsp_acc_in    = fin_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slbc_pkg::ST_IDLE;
         count_ff     <= '0;
         time_ff      <= '0;
         on_ff        <= '0;
         drive_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LED_COUNT; i++) begin
            last_ff[i]   <= '0;
            period_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         time_ff      <= time_in;
         on_ff        <= on_in;
         drive_ff     <= drive_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         period_ff    <= period_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      ptr_ff        <= ptr_in;
      rsp_levels_ff <= rsp_levels_in;
      rsp_acc_ff    <= rsp_acc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0000000, rsp_acc_ff, rsp_levels_ff};

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != slbc_pkg::ST_IDLE) |-> !rsp_valid_ff)
      else $error("Result register is occupied while an item is in progress.");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= POS_W'(LINE_LEN))
      else $error("Line count exceeds the buffer length.");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser[0]) |=> (time_ff == $past(time_ff) + 32'd1))
      else $error("Millisecond counter did not advance on a tick transfer.");

   assert property (@(posedge clock) disable iff (reset)
      (finish && fin_acc) |-> ((state_ff == slbc_pkg::ST_CHECK) ||
                               (state_ff == slbc_pkg::ST_SKIP) ||
                               (state_ff == slbc_pkg::ST_DIGIT)))
      else $error("Command accepted outside of line execution.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == slbc_pkg::ST_TICK) |=> !$changed(count_ff))
      else $error("Line count changed during a tick walk.");

endmodule
